@@ hdl/tvas_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt vector angle sector package
// Shared widths, the CORDIC stage record and the arctangent table for the
// tilt vector to angle sector pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tvas_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int DATA_W           = 20;
  localparam int TURN_W           = 16;
  localparam int CORDIC_STAGES    = 16;
  localparam int SECTOR_W         = 5;
  localparam int SECTOR_COUNT_DEF = 32;

  localparam logic [TURN_W-1:0] ZERO_TURN          = 16'h0000;
  localparam logic [TURN_W-1:0] QUARTER_TURN       = 16'h4000;
  localparam logic [TURN_W-1:0] HALF_TURN          = 16'h8000;
  localparam logic [TURN_W-1:0] THREE_QUARTER_TURN = 16'hC000;

  typedef struct packed {
    logic                     bypass;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [TURN_W-1:0]        z;
  } cordic_t;

  function automatic logic [TURN_W-1:0] atan_turn(input int idx);
    logic [TURN_W-1:0] a;
    case (idx)
      0:       a = 16'd8192;
      1:       a = 16'd4836;
      2:       a = 16'd2555;
      3:       a = 16'd1297;
      4:       a = 16'd651;
      5:       a = 16'd326;
      6:       a = 16'd163;
      7:       a = 16'd81;
      8:       a = 16'd41;
      9:       a = 16'd20;
      10:      a = 16'd10;
      11:      a = 16'd5;
      12:      a = 16'd3;
      13:      a = 16'd1;
      14:      a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ hdl/tvas_prep.sv @@
// ----------------------------------------------------------------------------
// Tilt vector angle sector input stage
// Scales and mirrors the sample pair into the right half plane and resolves
// the axis cases that skip the CORDIC rotations.
// ----------------------------------------------------------------------------
`default_nettype none

module tvas_prep
  import tvas_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       up_valid,
  output logic                            up_ready,
  input  wire logic signed [SAMPLE_W-1:0] accel_x,
  input  wire logic signed [SAMPLE_W-1:0] accel_y,
  output logic                            dn_valid,
  input  wire logic                       dn_ready,
  output cordic_t                         dn_data
);

  logic signed [DATA_W-1:0] x_scaled;
  logic signed [DATA_W-1:0] y_scaled;
  cordic_t                  data_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    x_scaled  = {{2{accel_x[SAMPLE_W-1]}}, accel_x, 2'b00};
    y_scaled  = -{{2{accel_y[SAMPLE_W-1]}}, accel_y, 2'b00};
    data_next = '0;
    if (accel_y == '0) begin
      data_next.bypass = 1'b1;
      data_next.z      = accel_x[SAMPLE_W-1] ? HALF_TURN : ZERO_TURN;
    end else if (accel_x == '0) begin
      data_next.bypass = 1'b1;
      data_next.z      = accel_y[SAMPLE_W-1] ? QUARTER_TURN : THREE_QUARTER_TURN;
    end else if (x_scaled[DATA_W-1]) begin
      data_next.x = -x_scaled;
      data_next.y = -y_scaled;
      data_next.z = HALF_TURN;
    end else begin
      data_next.x = x_scaled;
      data_next.y = y_scaled;
      data_next.z = ZERO_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tvas_cordic_stage.sv @@
// ----------------------------------------------------------------------------
// Tilt vector angle sector CORDIC stage
// One registered vectoring micro-rotation that drives Y toward zero and
// accumulates the rotated angle as a fraction of a turn.
// ----------------------------------------------------------------------------
`default_nettype none

module tvas_cordic_stage
  import tvas_pkg::*;
#(
  parameter int STAGE_IDX = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire cordic_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output cordic_t      dn_data
);

  localparam logic [TURN_W-1:0] ATAN_STEP = atan_turn(STAGE_IDX);

  cordic_t                  data_next;
  logic signed [DATA_W-1:0] x_shift;
  logic signed [DATA_W-1:0] y_shift;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    x_shift   = up_data.x >>> STAGE_IDX;
    y_shift   = up_data.y >>> STAGE_IDX;
    data_next = up_data;
    if (!up_data.bypass) begin
      if (!up_data.y[DATA_W-1]) begin
        data_next.x = up_data.x + y_shift;
        data_next.y = up_data.y - x_shift;
        data_next.z = up_data.z + ATAN_STEP;
      end else begin
        data_next.x = up_data.x - y_shift;
        data_next.y = up_data.y + x_shift;
        data_next.z = up_data.z - ATAN_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tvas_sector.sv @@
// ----------------------------------------------------------------------------
// Tilt vector angle sector output stage
// Scales the turn fraction by the sector count and registers the sector index
// as the output register of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tvas_sector
  import tvas_pkg::*;
#(
  parameter int SECTOR_COUNT = SECTOR_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire cordic_t            up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output logic [SECTOR_W-1:0]     sector
);

  localparam int COUNT_W = $clog2(SECTOR_COUNT) + 1;
  localparam logic [COUNT_W-1:0] COUNT = COUNT_W'(SECTOR_COUNT);

  logic [TURN_W+COUNT_W-1:0]   product;
  logic [COUNT_W+SECTOR_W-1:0] index;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    product = {{COUNT_W{1'b0}}, up_data.z} * {{TURN_W{1'b0}}, COUNT};
    index   = {{SECTOR_W{1'b0}}, product[TURN_W+COUNT_W-1:TURN_W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sector <= index[SECTOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hdl/tilt_vector_to_angle_sector.sv @@
// A request passes the prep, CORDIC stage and sector registers in turn.
// Throughput: one request per cycle unless stalled, one rotation per stage.
// Every stage holds its item while the next one is full and stalled.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Tilt vector to angle sector
// Pipelined CORDIC vectoring of the accelerometer X/Y pair followed by
// quantization of the angle into equal sectors.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_vector_to_angle_sector
  import tvas_pkg::*;
#(
  parameter int SECTOR_COUNT = SECTOR_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accel_valid,
  output logic                            accel_stall,
  input  wire logic signed [SAMPLE_W-1:0] accel_x,
  input  wire logic signed [SAMPLE_W-1:0] accel_y,
  output logic                            sector_valid,
  input  wire logic                       sector_stall,
  output logic [SECTOR_W-1:0]             sector
);

  cordic_t stg_data  [0:CORDIC_STAGES];
  logic    stg_valid [0:CORDIC_STAGES];
  logic    stg_ready [0:CORDIC_STAGES+1];

  tvas_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (accel_valid),
    .up_ready (stg_ready[0]),
    .accel_x  (accel_x),
    .accel_y  (accel_y),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[1]),
    .dn_data  (stg_data[0])
  );

  assign accel_stall = !stg_ready[0];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    tvas_cordic_stage #(
      .STAGE_IDX (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k+1]),
      .up_data  (stg_data[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+2]),
      .dn_data  (stg_data[k+1])
    );
  end

  tvas_sector #(
    .SECTOR_COUNT (SECTOR_COUNT)
  ) u_sector (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stg_valid[CORDIC_STAGES]),
    .up_ready (stg_ready[CORDIC_STAGES+1]),
    .up_data  (stg_data[CORDIC_STAGES]),
    .dn_valid (sector_valid),
    .dn_ready (!sector_stall),
    .sector   (sector)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt vector to angle sector testbench
// Drives accelerometer X/Y requests into the CORDIC sector pipeline in random
// bursts while the result side stalls on its own pattern. Every request's
// sector is predicted by a bit-exact fixed-point vectoring model and checked
// in order against the pipeline output.
// ----------------------------------------------------------------------------

module testbench
  import tvas_pkg::*;
();

  localparam int  SECTORS       = SECTOR_COUNT_DEF;
  localparam int  ITEMS         = 1950;
  localparam int  LONG_HOLD     = 300;
  localparam int  DRAIN_CYCLES  = 40;
  localparam int  STALL_LIMIT   = 2000;
  localparam int  REPORT_LIMIT  = 10;
  localparam int  DIRECTED_N    = 24;
  localparam real PI            = 3.14159265358979;

  localparam logic [TURN_W-1:0] ATAN_STEP [CORDIC_STAGES] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
  };

  localparam int EDGE_VALUES [6] = '{-32768, -32767, -1, 0, 1, 32767};

  localparam int DIRECTED_X [DIRECTED_N] = '{
    0, 32767, -32768, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767,
    -32768, 1, 1, -1, -1, 100, -100, 32767, 32767, -32768, -32768, 21845
  };
  localparam int DIRECTED_Y [DIRECTED_N] = '{
    0, 0, 0, 32767, -32768, 1, -1, 0, 0, 32767, -32768, -32768,
    32767, 1, -1, 1, -1, -32768, -32768, 1, -1, 1, -1, -10922
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic [SECTOR_W-1:0]        sector;
  } sector_request_t;

  class sector_scoreboard;
    sector_request_t pending_sectors[$];
    int failures;
    int reports;

    function logic [SECTOR_W-1:0] predict_sector(logic signed [SAMPLE_W-1:0] x,
                                                 logic signed [SAMPLE_W-1:0] y);
      int vx;
      int vy;
      int dx;
      int dy;
      int unsigned scaled;
      logic [TURN_W-1:0] turn;
      turn = ZERO_TURN;
      if (y == 0) begin
        turn = (x < 0) ? HALF_TURN : ZERO_TURN;
      end else if (x == 0) begin
        turn = (y < 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
      end else begin
        vx = 4 * int'(x);
        vy = -4 * int'(y);
        if (vx < 0) begin
          vx = -vx;
          vy = -vy;
          turn = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
          dx = vy >>> i;
          dy = vx >>> i;
          if (vy >= 0) begin
            vx += dx;
            vy -= dy;
            turn += ATAN_STEP[i];
          end else begin
            vx -= dx;
            vy += dy;
            turn -= ATAN_STEP[i];
          end
        end
      end
      scaled = (32'(turn) * SECTORS) >> TURN_W;
      return scaled[SECTOR_W-1:0];
    endfunction

    function void note_request(logic signed [SAMPLE_W-1:0] x,
                               logic signed [SAMPLE_W-1:0] y);
      sector_request_t req;
      req.x = x;
      req.y = y;
      req.sector = predict_sector(x, y);
      pending_sectors.push_back(req);
    endfunction

    function void check_result(logic [SECTOR_W-1:0] sector);
      sector_request_t req;
      if (pending_sectors.size() == 0) begin
        failures++;
        if (reports++ < REPORT_LIMIT)
          $display("%0t: sector %0d arrived with no request pending", $realtime, sector);
      end else begin
        req = pending_sectors.pop_front();
        if (sector !== req.sector) begin
          failures++;
          if (reports++ < REPORT_LIMIT)
            $display("%0t: x=%0d y=%0d expected sector %0d, got %0d",
                     $realtime, req.x, req.y, req.sector, sector);
        end
      end
    endfunction

    function int pending();
      return pending_sectors.size();
    endfunction

    function void close_out();
      if (pending_sectors.size() != 0) begin
        failures += pending_sectors.size();
        $display("%0d requests never produced a sector", pending_sectors.size());
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       accel_valid;
  logic                       accel_stall;
  logic signed [SAMPLE_W-1:0] accel_x;
  logic signed [SAMPLE_W-1:0] accel_y;
  logic                       sector_valid;
  logic                       sector_stall;
  logic [SECTOR_W-1:0]        sector;

  sector_scoreboard sb;
  logic hold_request;
  int   idle_cycles;

  tilt_vector_to_angle_sector #(
    .SECTOR_COUNT(SECTORS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .accel_valid (accel_valid),
    .accel_stall (accel_stall),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .sector_valid(sector_valid),
    .sector_stall(sector_stall),
    .sector      (sector)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (accel_valid && !accel_stall)
        sb.note_request(accel_x, accel_y);
      if (sector_valid && !sector_stall)
        sb.check_result(sector);
      if ((accel_valid && !accel_stall) || (sector_valid && !sector_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("timeout after %0d cycles with no transfer", STALL_LIMIT);
        $display("** tilt_vector_to_angle_sector: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int span;
    sector_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        if (hold_request) begin
          sector_stall = 1'b1;
          repeat (LONG_HOLD) @(negedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0:       sector_stall = 1'b0;
          1:       sector_stall = ($urandom_range(0, 3) == 0);
          2:       sector_stall = ($urandom_range(0, 3) != 0);
          default: sector_stall = ((c % 4) < 2);
        endcase
      end
    end
  end

  task automatic offer(input logic signed [SAMPLE_W-1:0] x,
                       input logic signed [SAMPLE_W-1:0] y);
    accel_valid = 1'b1;
    accel_x = x;
    accel_y = y;
    do @(posedge clk); while (accel_stall);
    @(negedge clk);
  endtask

  task automatic pick_vector(output logic signed [SAMPLE_W-1:0] x,
                             output logic signed [SAMPLE_W-1:0] y);
    int  kind;
    int  radius;
    real angle;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      x = SAMPLE_W'($urandom);
      y = SAMPLE_W'($urandom);
    end else if (kind < 60) begin
      x = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      y = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
    end else if (kind < 70) begin
      if ($urandom_range(0, 1)) begin
        x = '0;
        y = SAMPLE_W'($urandom);
      end else begin
        x = SAMPLE_W'($urandom);
        y = '0;
      end
    end else if (kind < 80) begin
      x = SAMPLE_W'(EDGE_VALUES[$urandom_range(0, 5)]);
      y = SAMPLE_W'(EDGE_VALUES[$urandom_range(0, 5)]);
    end else begin
      radius = $urandom_range(4, 32767);
      angle = (2.0 * PI / SECTORS) * $urandom_range(0, SECTORS - 1)
              + (real'($urandom_range(0, 200)) - 100.0) * 1.0e-4;
      x = SAMPLE_W'($rtoi(radius * $cos(angle)));
      y = SAMPLE_W'(-$rtoi(radius * $sin(angle)));
    end
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    bit held;
    bit paused;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    sb = new();
    rst = 1'b1;
    accel_valid = 1'b0;
    accel_x = '0;
    accel_y = '0;
    hold_request = 1'b0;
    idle_cycles = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_N; i++)
      offer(SAMPLE_W'(DIRECTED_X[i]), SAMPLE_W'(DIRECTED_Y[i]));
    sent = DIRECTED_N;

    while (sent < ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        pick_vector(x, y);
        offer(x, y);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        accel_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      if (!held && sent >= 600) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if (!paused && sent >= 1300) begin
        accel_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        paused = 1'b1;
      end
    end

    accel_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("** tilt_vector_to_angle_sector: PASSED **");
    end else begin
      $display("** tilt_vector_to_angle_sector: FAILED **");
    end
    $finish;
  end

endmodule
